// File: rtl/cmbh_pkg.sv
// ----------------------------------------------------------------------------
// cmbh_pkg
// Shared types, codes and helpers for the coprocessor mailbox boot
// handshake: word layouts, command and result kinds, message types.
// ----------------------------------------------------------------------------
package cmbh_pkg;

    localparam int ENDPOINT_COUNT_DEF = 256;
    localparam int CHUNK_BITS         = 32;
    localparam int MAX_RESULTS        = 5;

    localparam logic [15:0] LOWEST_VERSION_RST  = 16'd11;
    localparam logic [15:0] HIGHEST_VERSION_RST = 16'd12;

    // configuration register indexes
    localparam int          CFG_IDX_W           = 8;
    localparam logic [7:0]  CFG_LOWEST_VERSION  = 8'd0;
    localparam logic [7:0]  CFG_HIGHEST_VERSION = 8'd1;

    // input commands
    localparam logic [1:0] CMD_INBOUND = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_SEND    = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_TO_COPRO  = 3'd0;
    localparam logic [2:0] KIND_TO_CLIENT = 3'd1;
    localparam logic [2:0] KIND_BOOTED    = 3'd2;
    localparam logic [2:0] KIND_BUF_REQ   = 3'd3;
    localparam logic [2:0] KIND_REJECT    = 3'd4;

    // endpoints
    localparam logic [7:0] EP_MGMT      = 8'h00;
    localparam logic [7:0] EP_CRASHLOG  = 8'h01;
    localparam logic [7:0] EP_SYSLOG    = 8'h02;
    localparam logic [7:0] EP_IOREPORT  = 8'h04;
    localparam logic [7:0] EP_APP_FIRST = 8'h20;

    // message types, bits 59..52
    localparam logic [7:0] MT_HELLO      = 8'h01;
    localparam logic [7:0] MT_HELLO_ACK  = 8'h02;
    localparam logic [7:0] MT_START_EP   = 8'h05;
    localparam logic [7:0] MT_BOOT_DONE  = 8'h07;
    localparam logic [7:0] MT_EPMAP      = 8'h08;
    localparam logic [7:0] MT_BOOT_DONE2 = 8'h0b;
    localparam logic [7:0] MT_SYSLOG_LOG = 8'h05;
    localparam logic [7:0] MT_IOREP_A    = 8'h08;
    localparam logic [7:0] MT_IOREP_B    = 8'h0c;

    localparam logic [63:0] EPMAP_LAST_FLAG = 64'h0008_0000_0000_0000;
    localparam logic [63:0] EPMAP_MORE_FLAG = 64'h1;
    localparam logic [31:0] START_FLAG      = 32'h2;
    localparam logic [63:0] BOOT_DONE_ARG   = 64'h20;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  endpoint;
        logic [63:0] message_word;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_endpoint;
        logic [63:0] out_message;
        logic        last;
    } t_out_word;

    // build a result word; last is settled at the output
    function automatic t_out_word make_out(logic [2:0] kind, logic [7:0] ep,
                                           logic [63:0] msg);
        t_out_word w;
        w.kind         = kind;
        w.out_endpoint = ep;
        w.out_message  = msg;
        w.last         = 1'b0;
        return w;
    endfunction

    // management reply to endpoint 0: type field replaced
    function automatic t_out_word mgmt_out(logic [7:0] mtype, logic [63:0] body);
        return make_out(KIND_TO_COPRO, EP_MGMT, {body[63:60], mtype, body[51:0]});
    endfunction

    function automatic logic [63:0] start_body(logic [7:0] ep);
        return {24'd0, ep, START_FLAG};
    endfunction

endpackage

// File: rtl/cmbh_ram.sv
// ----------------------------------------------------------------------------
// cmbh_ram
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents when the same address is written.
// ----------------------------------------------------------------------------
module cmbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/coprocessor_mailbox_boot_handshake.sv
// ----------------------------------------------------------------------------
// coprocessor_mailbox_boot_handshake
// Host side of the coprocessor mailbox boot handshake: version hello,
// endpoint map collection, boot-done replies, start and send requests.
// ----------------------------------------------------------------------------
// Flow: an accepted input is held in the work stage while its map row is read;
//   its result list is loaded into the output stage once that stage is free,
//   and the first result word is offered from there.
// Throughput: one input word per cycle while each gives at most one result and
//   the output is not stalled; an input giving several results (up to five)
//   holds the output stage until all are taken, one result word per cycle while the output is ready.
// Reset: clears flags, version registers (to 11 and 12), the booted flag and
//   the per-row valid bits of the endpoint map; no clearing pass is needed.
// ----------------------------------------------------------------------------
module coprocessor_mailbox_boot_handshake #(
    parameter int ENDPOINT_COUNT = cmbh_pkg::ENDPOINT_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  cmbh_pkg::t_in_word                 i_in_word,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output cmbh_pkg::t_out_word                o_out_word,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cmbh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);

    import cmbh_pkg::*;

    // The endpoint map lives in a RAM of 32-bit rows, one row per map chunk.
    localparam int ROWS  = ENDPOINT_COUNT / CHUNK_BITS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int BIT_W = $clog2(CHUNK_BITS);
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W = $clog2(MAX_RESULTS);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    logic [15:0]           r_lowest;
    logic [15:0]           r_highest;
    logic                  r_booted;
    logic [15:0]           r_agreed;

    // work stage: holds the word whose map row is being read
    logic                  r_b_valid;
    t_in_word              r_b_word;

    // row valid bits stand in for clearing the map RAM
    logic [ROWS-1:0]       r_row_valid;

    // last write, forwarded over the registered read of the map RAM
    logic                  r_fwd_valid;
    logic [ROW_W-1:0]      r_fwd_row;
    logic [CHUNK_BITS-1:0] r_fwd_data;

    // output stage: up to five result words, drained one per cycle while the output is ready
    logic                  r_e_valid;
    t_out_word             r_res [MAX_RESULTS];
    logic [CNT_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      r_idx;

    // ---------------------------------------------------------------------
    // Handshake control
    // ---------------------------------------------------------------------
    logic                  in_accept;
    logic                  e_take;
    logic                  e_last;
    logic                  emit_free;
    logic                  b_fire;

    assign e_take    = r_e_valid & i_out_ready;
    assign e_last    = (CNT_W'(r_idx) == r_cnt - CNT_W'(1));
    assign emit_free = ~r_e_valid | (e_take & e_last);
    assign b_fire    = r_b_valid & emit_free;
    assign o_in_ready = ~r_b_valid | b_fire;
    assign in_accept = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Map RAM: two copies written alike; the second always reads row 0,
    // which the last map chunk needs for the system endpoint starts.
    // ---------------------------------------------------------------------
    logic [ROW_W-1:0]      in_row;
    logic [ROW_W-1:0]      b_row;
    logic [ROW_W-1:0]      ram_rd_addr;
    logic [CHUNK_BITS-1:0] ram_rd_data;
    logic [CHUNK_BITS-1:0] ram0_rd_data;
    logic                  wr_en;
    logic [CHUNK_BITS-1:0] wr_data;

    // start requests read the endpoint's row, map chunks their chunk row
    assign in_row = (i_in_word.command == CMD_START) ?
                    i_in_word.endpoint[BIT_W +: ROW_W] :
                    i_in_word.message_word[32 +: ROW_W];
    assign b_row  = (r_b_word.command == CMD_START) ?
                    r_b_word.endpoint[BIT_W +: ROW_W] :
                    r_b_word.message_word[32 +: ROW_W];

    // a stalled word keeps re-reading its own row so the data stays fresh
    assign ram_rd_addr = in_accept ? in_row : b_row;

    cmbh_ram #(
        .WIDTH (CHUNK_BITS),
        .DEPTH (ROWS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (b_row),
        .i_wr_data (wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    cmbh_ram #(
        .WIDTH (CHUNK_BITS),
        .DEPTH (ROWS)
    ) u_map_row0_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (b_row),
        .i_wr_data (wr_data),
        .i_rd_addr (ROW_W'(0)),
        .o_rd_data (ram0_rd_data)
    );

    // resolve row contents: forwarded write first, then RAM if ever written
    logic [CHUNK_BITS-1:0] row_data;
    logic [CHUNK_BITS-1:0] row0_data;

    always_comb begin
        if (r_fwd_valid && r_fwd_row == b_row) begin
            row_data = r_fwd_data;
        end else if (r_row_valid[b_row]) begin
            row_data = ram_rd_data;
        end else begin
            row_data = '0;
        end
    end

    always_comb begin
        if (r_fwd_valid && r_fwd_row == ROW_W'(0)) begin
            row0_data = r_fwd_data;
        end else if (r_row_valid[0]) begin
            row0_data = ram0_rd_data;
        end else begin
            row0_data = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Work stage: decode the word and build its result list
    // ---------------------------------------------------------------------
    t_out_word             res [MAX_RESULTS];
    logic [CNT_W-1:0]      cnt;
    logic                  map_write;
    logic                  set_booted;
    logic                  set_agreed;
    logic [15:0]           agreed_next;

    always_comb begin
        logic [63:0]           msg;
        logic [7:0]            ep;
        logic [7:0]            mtype;
        logic [15:0]           minv;
        logic [15:0]           maxv;
        logic [15:0]           want;
        logic [CHUNK_BITS-1:0] merged;
        logic [CHUNK_BITS-1:0] r0;
        logic                  is_last;

        msg     = r_b_word.message_word;
        ep      = r_b_word.endpoint;
        mtype   = msg[59:52];
        minv    = msg[15:0];
        maxv    = msg[31:16];
        want    = (maxv < r_highest) ? maxv : r_highest;
        merged  = row_data | msg[CHUNK_BITS-1:0];
        r0      = (b_row == ROW_W'(0)) ? merged : row0_data;
        is_last = msg[51];

        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[IDX_W'(k)] = make_out(KIND_TO_COPRO, EP_MGMT, 64'd0);
        end
        cnt         = '0;
        map_write   = 1'b0;
        set_booted  = 1'b0;
        set_agreed  = 1'b0;
        agreed_next = want;
        wr_data     = merged;

        unique case (r_b_word.command)
            CMD_INBOUND: begin
                if (ep == EP_MGMT) begin
                    unique case (mtype)
                        MT_HELLO: begin
                            // drop an offer outside our supported range
                            if (!(minv > r_highest || maxv < r_lowest)) begin
                                set_agreed = 1'b1;
                                res[0] = mgmt_out(MT_HELLO_ACK, {32'd0, want, want});
                                cnt    = CNT_W'(1);
                            end
                        end
                        MT_EPMAP: begin
                            map_write = 1'b1;
                            res[0] = mgmt_out(MT_EPMAP, {29'd0, msg[34:32], 32'd0} |
                                              (is_last ? EPMAP_LAST_FLAG
                                                       : EPMAP_MORE_FLAG));
                            cnt = CNT_W'(1);
                            // start present system endpoints, ascending
                            if (is_last) begin
                                for (int i = 1; i <= 4; i++) begin
                                    if (r0[BIT_W'(i)]) begin
                                        res[cnt[IDX_W-1:0]] =
                                            mgmt_out(MT_START_EP, start_body(8'(i)));
                                        cnt = cnt + CNT_W'(1);
                                    end
                                end
                            end
                        end
                        MT_BOOT_DONE: begin
                            res[0] = mgmt_out(MT_BOOT_DONE2, BOOT_DONE_ARG);
                            cnt    = CNT_W'(1);
                        end
                        MT_BOOT_DONE2: begin
                            set_booted = 1'b1;
                            res[0] = make_out(KIND_BOOTED, EP_MGMT, 64'd0);
                            cnt    = CNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end else if (ep == EP_CRASHLOG || ep == EP_SYSLOG ||
                             ep == EP_IOREPORT) begin
                    if (mtype == MT_HELLO) begin
                        res[0] = make_out(KIND_BUF_REQ, ep, msg);
                        cnt    = CNT_W'(1);
                    end else if (ep == EP_SYSLOG && mtype == MT_SYSLOG_LOG) begin
                        res[0] = make_out(KIND_TO_COPRO, EP_SYSLOG, msg);
                        cnt    = CNT_W'(1);
                    end else if (ep == EP_IOREPORT &&
                                 (mtype == MT_IOREP_A || mtype == MT_IOREP_B)) begin
                        res[0] = make_out(KIND_TO_COPRO, EP_IOREPORT, msg);
                        cnt    = CNT_W'(1);
                    end
                end else if (ep >= EP_APP_FIRST) begin
                    res[0] = make_out(KIND_TO_CLIENT, ep, msg);
                    cnt    = CNT_W'(1);
                end
            end
            CMD_START: begin
                if (!row_data[ep[BIT_W-1:0]] || (ep >= EP_APP_FIRST && !r_booted)) begin
                    res[0] = make_out(KIND_REJECT, ep, 64'd0);
                end else begin
                    res[0] = mgmt_out(MT_START_EP, start_body(ep));
                end
                cnt = CNT_W'(1);
            end
            CMD_SEND: begin
                if (ep > EP_APP_FIRST && !r_booted) begin
                    res[0] = make_out(KIND_REJECT, ep, 64'd0);
                end else begin
                    res[0] = make_out(KIND_TO_COPRO, ep, msg);
                end
                cnt = CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign wr_en = b_fire & map_write;

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest    <= LOWEST_VERSION_RST;
            r_highest   <= HIGHEST_VERSION_RST;
            r_booted    <= 1'b0;
            r_agreed    <= '0;
            r_b_valid   <= 1'b0;
            r_row_valid <= '0;
            r_fwd_valid <= 1'b0;
            r_e_valid   <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
        end else begin
            // configuration: unknown indexes are dropped
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LOWEST_VERSION:  r_lowest  <= i_cfg_data;
                    CFG_HIGHEST_VERSION: r_highest <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // work stage occupancy
            if (in_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end

            // state updates of the word leaving the work stage
            if (b_fire && set_booted) begin
                r_booted <= 1'b1;
            end
            if (b_fire && set_agreed) begin
                r_agreed <= agreed_next;
            end
            if (wr_en) begin
                r_row_valid[b_row] <= 1'b1;
            end
            r_fwd_valid <= wr_en;

            // output stage: load a fresh list or advance through the held one
            if (b_fire) begin
                r_e_valid <= (cnt != '0);
                r_cnt     <= cnt;
                r_idx     <= '0;
            end else if (e_take) begin
                if (e_last) begin
                    r_e_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_word <= i_in_word;
        end
        if (wr_en) begin
            r_fwd_row  <= b_row;
            r_fwd_data <= wr_data;
        end
        if (b_fire) begin
            r_res <= res;
        end
    end

    // ---------------------------------------------------------------------
    // Outputs
    // ---------------------------------------------------------------------
    always_comb begin
        o_out_word      = r_res[r_idx];
        o_out_word.last = e_last;
    end

    assign o_out_valid = r_e_valid;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_cnt != '0) && (CNT_W'(r_idx) < r_cnt))
        else $error("output index beyond result count");

    a_stall_holds_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && !i_out_ready) |=> (r_e_valid && $stable(r_idx)))
        else $error("result list advanced while output stalled");

    a_booted_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_booted |=> r_booted)
        else $error("booted flag cleared");

    a_fwd_after_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> $past(b_fire))
        else $error("map forward without a retiring word");

    a_agreed_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_agreed != $past(r_agreed)) |-> $past(b_fire))
        else $error("agreed version changed outside a hello");

endmodule
